// ===== hw/rtl/lnde_pkg.sv =====
package lnde_pkg;

  localparam int LINE_W = 11;
  localparam int UNITS_W = 3;
  localparam int OFS_W = 13;
  localparam int PB_W = 14;
  localparam int PL_W = 12;
  localparam int ACC_W = 15;
  localparam int BYTE_W = 8;

  localparam logic [OFS_W-1:0] MAX_CODE_UNITS = OFS_W'(4096);
  localparam logic [LINE_W-1:0] MAX_LINE = LINE_W'(2047);

  // Split limits for one table word.
  localparam logic [PB_W-1:0] BYTE_CHUNK = PB_W'(255);
  localparam logic signed [PL_W-1:0] LINE_UP = PL_W'(127);
  localparam logic signed [PL_W-1:0] LINE_DOWN = -PL_W'(128);

  // Addends used by the shared step adder.
  localparam logic signed [ACC_W-1:0] ADD_BYTE_STEP = -ACC_W'(255);
  localparam logic signed [ACC_W-1:0] ADD_LINE_UP = -ACC_W'(127);
  localparam logic signed [ACC_W-1:0] ADD_LINE_DOWN = ACC_W'(128);

  localparam logic ACT_INSN = 1'b0;
  localparam logic ACT_RESTART = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } lnde_state_e;

endpackage

// ===== hw/rtl/lnde_if.sv =====
interface lnde_in_if;
  logic valid;
  logic ready;
  logic action;
  logic [lnde_pkg::LINE_W-1:0] line_number;
  logic [lnde_pkg::UNITS_W-1:0] unit_count;

  modport source (output valid, action, line_number, unit_count, input ready);
  modport sink (input valid, action, line_number, unit_count, output ready);
endinterface

interface lnde_out_if;
  logic valid;
  logic ready;
  logic [lnde_pkg::BYTE_W-1:0] byte_delta;
  logic signed [lnde_pkg::BYTE_W-1:0] line_delta;
  logic last_pair;
  logic code_overflow;

  modport source (output valid, byte_delta, line_delta, last_pair, code_overflow,
                  input ready);
  modport sink (input valid, byte_delta, line_delta, last_pair, code_overflow,
                output ready);
endinterface

// ===== hw/rtl/line_number_delta_encoder_top.sv =====
// Line number table encoder: each instruction word (source line, length in code units)
// is taken in the idle state and leaves it idle when the line is unchanged. A line
// change starts a run of table words; the encoder then stays busy until the last word
// is emitted, where the run is 1 + ceil-split of the byte advance by 255 plus the split
// of the line advance by 127 or 128 (at most 49 words), since one shared adder produces
// one word per cycle. A stalled output stalls the run; a finished word may wait in the
// output register while the next instruction is already taken. A restart word emits
// nothing.
module line_number_delta_encoder_top (
  input logic clk_i,
  input logic rst_ni,
  lnde_in_if.sink in_i,
  lnde_out_if.source out_o
);

  lnde_pkg::lnde_state_e state_q, state_d;

  logic [lnde_pkg::LINE_W-1:0] cur_line_q, cur_line_d;
  logic [lnde_pkg::OFS_W-1:0] offset_q, offset_d;
  logic [lnde_pkg::OFS_W-1:0] start_q, start_d;
  logic ovf_q, ovf_d;
  logic ovf_snap_q, ovf_snap_d;
  logic [lnde_pkg::PB_W-1:0] pb_q, pb_d;
  logic signed [lnde_pkg::PL_W-1:0] pl_q, pl_d;

  logic out_valid_q, out_valid_d;
  logic [lnde_pkg::BYTE_W-1:0] out_byte_q, out_byte_d;
  logic signed [lnde_pkg::BYTE_W-1:0] out_line_q, out_line_d;
  logic out_last_q, out_last_d;
  logic out_ovf_q, out_ovf_d;

  logic accept;
  logic slot_free;
  logic emit;
  logic emit_last;
  logic byte_step, up_step, down_step;
  logic signed [lnde_pkg::ACC_W-1:0] acc_a, acc_b, acc_sum;
  logic [lnde_pkg::LINE_W-1:0] line_clamped;
  logic [lnde_pkg::OFS_W-1:0] span;
  logic [lnde_pkg::OFS_W:0] offset_sum;

  assign in_i.ready = (state_q == lnde_pkg::ST_IDLE);
  assign accept = in_i.valid && in_i.ready;
  assign slot_free = !out_valid_q || out_o.ready;

  assign out_o.valid = out_valid_q;
  assign out_o.byte_delta = out_byte_q;
  assign out_o.line_delta = out_line_q;
  assign out_o.last_pair = out_last_q;
  assign out_o.code_overflow = out_ovf_q;

  assign line_clamped = (in_i.line_number > lnde_pkg::MAX_LINE) ? lnde_pkg::MAX_LINE
                                                                  : in_i.line_number;
  assign span = offset_q - start_q;
  assign offset_sum = {1'b0, offset_q} + (lnde_pkg::OFS_W + 1)'(in_i.unit_count);

  // Byte splitting comes first; line splitting follows once the bytes fit.
  assign byte_step = pb_q > lnde_pkg::BYTE_CHUNK;
  assign up_step = pl_q > lnde_pkg::LINE_UP;
  assign down_step = pl_q < lnde_pkg::LINE_DOWN;

  // The one step adder shared by all split phases.
  always_comb begin
    if (byte_step) begin
      acc_a = lnde_pkg::ACC_W'(pb_q);
      acc_b = lnde_pkg::ADD_BYTE_STEP;
    end else begin
      acc_a = lnde_pkg::ACC_W'(pl_q);
      acc_b = up_step ? lnde_pkg::ADD_LINE_UP : lnde_pkg::ADD_LINE_DOWN;
    end
    acc_sum = acc_a + acc_b;
  end

  always_comb begin
    state_d = state_q;
    cur_line_d = cur_line_q;
    offset_d = offset_q;
    start_d = start_q;
    ovf_d = ovf_q;
    ovf_snap_d = ovf_snap_q;
    pb_d = pb_q;
    pl_d = pl_q;
    emit = 1'b0;
    emit_last = 1'b0;
    out_byte_d = out_byte_q;
    out_line_d = out_line_q;
    out_last_d = out_last_q;
    out_ovf_d = out_ovf_q;

    unique case (state_q)
      lnde_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_i.action == lnde_pkg::ACT_RESTART) begin
            cur_line_d = line_clamped;
            offset_d = '0;
            start_d = '0;
            ovf_d = 1'b0;
          end else begin
            if (line_clamped != cur_line_q) begin
              pb_d = (offset_q >= start_q) ? {span, 1'b0} : '0;
              pl_d = $signed({1'b0, line_clamped}) - $signed({1'b0, cur_line_q});
              ovf_snap_d = ovf_q;
              cur_line_d = line_clamped;
              start_d = offset_q;
              state_d = lnde_pkg::ST_EMIT;
            end
            if (offset_sum > (lnde_pkg::OFS_W + 1)'(lnde_pkg::MAX_CODE_UNITS)) begin
              offset_d = lnde_pkg::MAX_CODE_UNITS;
              ovf_d = 1'b1;
            end else begin
              offset_d = offset_sum[lnde_pkg::OFS_W-1:0];
            end
          end
        end
      end
      lnde_pkg::ST_EMIT: begin
        if (slot_free) begin
          emit = 1'b1;
          out_ovf_d = ovf_snap_q;
          out_last_d = 1'b0;
          if (byte_step) begin
            out_byte_d = lnde_pkg::BYTE_CHUNK[lnde_pkg::BYTE_W-1:0];
            out_line_d = '0;
            pb_d = acc_sum[lnde_pkg::PB_W-1:0];
          end else if (up_step || down_step) begin
            out_byte_d = pb_q[lnde_pkg::BYTE_W-1:0];
            out_line_d = up_step ? lnde_pkg::LINE_UP[lnde_pkg::BYTE_W-1:0]
                                 : lnde_pkg::LINE_DOWN[lnde_pkg::BYTE_W-1:0];
            pb_d = '0;
            pl_d = acc_sum[lnde_pkg::PL_W-1:0];
          end else begin
            emit_last = 1'b1;
            out_byte_d = pb_q[lnde_pkg::BYTE_W-1:0];
            out_line_d = pl_q[lnde_pkg::BYTE_W-1:0];
            out_last_d = 1'b1;
            pb_d = '0;
            pl_d = '0;
            state_d = lnde_pkg::ST_IDLE;
          end
        end
      end
      default: state_d = lnde_pkg::ST_IDLE;
    endcase

    out_valid_d = emit || (out_valid_q && !out_o.ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lnde_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_line_q <= '0;
      offset_q <= '0;
      start_q <= '0;
      ovf_q <= 1'b0;
      ovf_snap_q <= 1'b0;
      pb_q <= '0;
      pl_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cur_line_q <= cur_line_d;
      offset_q <= offset_d;
      start_q <= start_d;
      ovf_q <= ovf_d;
      ovf_snap_q <= ovf_snap_d;
      pb_q <= pb_d;
      pl_q <= pl_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    out_line_q <= out_line_d;
    out_last_q <= out_last_d;
    out_ovf_q <= out_ovf_d;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    offset_q <= lnde_pkg::MAX_CODE_UNITS)
    else $error("code offset above its saturation limit");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> (offset_q == lnde_pkg::MAX_CODE_UNITS))
    else $error("overflow flag set without a saturated offset");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_last |=> (state_q == lnde_pkg::ST_IDLE) && out_valid_q && out_last_q)
    else $error("final word did not end the run");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && !byte_step) |=> (pb_q == '0))
    else $error("byte advance left over after a line word");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lnde_pkg::ST_IDLE) |-> (pb_q == '0) && (pl_q == '0))
    else $error("split run not cleared between items");

endmodule
